### src/thc_pkg.sv
package thc_pkg;

   localparam int RAW_TEMP_W = 20;
   localparam int RAW_HUM_W  = 16;
   localparam int TEMP_W     = 16;
   localparam int HUM_W      = 17;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;

   // register map
   localparam logic [CSR_IDX_W-1:0] REG_T1  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_T2  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_T3  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_H13 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_H2  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_H4  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_H5  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_H6  = 3'd7;

   // formula constants
   localparam logic signed [31:0] T_ROUND       = 32'sd128;
   localparam logic signed [31:0] FINE_OFFSET   = 32'sd76800;
   localparam logic signed [31:0] P_ROUND       = 32'sd16384;
   localparam logic signed [31:0] Q_BIAS        = 32'sd32768;
   localparam logic signed [31:0] Q2_BIAS       = 32'sd2097152;
   localparam logic signed [31:0] Q3_ROUND      = 32'sd8192;
   localparam logic signed [31:0] HUM_CLAMP_MAX = 32'sd419430400;
   localparam logic signed [31:0] TEMP_MAX      = 32'sd32767;
   localparam logic signed [31:0] TEMP_MIN      = -32'sd32768;
   localparam logic [HUM_W-1:0]   HUM_OUT_MAX   = 17'd102400;

   typedef struct packed {
      logic        [15:0] t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic        [7:0]  h1;
      logic        [7:0]  h3;
      logic signed [15:0] h2;
      logic signed [15:0] h4;
      logic signed [15:0] h5;
      logic signed [7:0]  h6;
   } coeff_type;

endpackage

### src/thc_if.sv
interface thc_req_if;
   logic                             valid;
   logic                             ready;
   logic [thc_pkg::RAW_TEMP_W-1:0]   raw_temp;
   logic [thc_pkg::RAW_HUM_W-1:0]    raw_humidity;

   modport source (output valid, raw_temp, raw_humidity, input ready);
   modport sink   (input valid, raw_temp, raw_humidity, output ready);
endinterface

interface thc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [thc_pkg::TEMP_W-1:0] temp_centi;
   logic [thc_pkg::HUM_W-1:0]        humidity_q10;

   modport source (output valid, temp_centi, humidity_q10, input ready);
   modport sink   (input valid, temp_centi, humidity_q10, output ready);
endinterface

### src/temp_humidity_compensation_top.sv
// Temperature/humidity compensation, 32-bit integer formula.
// The result passes through 9 pipeline stages and then the output register.
// Throughput: one item per cycle while the skid entry is free; the pipeline
// is frozen while the skid entry holds an item.
// Output register plus a one-entry skid buffer keep req ready off rsp ready.
// Reset (synchronous, active high) clears valid bits and all coefficients.
module temp_humidity_compensation_top (
   input  logic                             clock,
   input  logic                             reset,
   thc_req_if.sink                          req_ch,
   thc_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [thc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [thc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import thc_pkg::*;

   coeff_type coef_ff, coef_in;

   // pipeline advances whenever the skid entry is free
   logic en;
   logic pipe_valid;
   logic signed [TEMP_W-1:0] pipe_temp;
   logic [HUM_W-1:0] pipe_hum;

   logic rsp_valid_ff, skid_valid_ff;
   logic signed [TEMP_W-1:0] out_temp_ff, skid_temp_ff;
   logic [HUM_W-1:0] out_hum_ff, skid_hum_ff;
   logic out_take, incoming;

   // coefficient registers; the user must write them only while idle (not enforced here)
   always_comb begin
      coef_in = coef_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_T1:  coef_in.t1 = csr_wdata;
            REG_T2:  coef_in.t2 = csr_wdata;
            REG_T3:  coef_in.t3 = csr_wdata;
            REG_H13: begin
               coef_in.h1 = csr_wdata[7:0];
               coef_in.h3 = csr_wdata[15:8];
            end
            REG_H2:  coef_in.h2 = csr_wdata;
            REG_H4:  coef_in.h4 = csr_wdata;
            REG_H5:  coef_in.h5 = csr_wdata;
            REG_H6:  coef_in.h6 = csr_wdata[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign en           = !skid_valid_ff;
   assign req_ch.ready = en;

   thc_pipe u_pipe (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_ch.valid),
      .raw_temp     (req_ch.raw_temp),
      .raw_humidity (req_ch.raw_humidity),
      .coef         (coef_ff),
      .out_valid    (pipe_valid),
      .temp_centi   (pipe_temp),
      .humidity_q10 (pipe_hum)
   );

   // output register with skid entry
   assign out_take = !rsp_valid_ff || rsp_ch.ready;
   assign incoming = en && pipe_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_take) begin
         // skid drains first; pipeline is frozen while it holds an item
         rsp_valid_ff  <= skid_valid_ff || incoming;
         skid_valid_ff <= 1'b0;
      end else if (incoming) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         if (skid_valid_ff) begin
            out_temp_ff <= skid_temp_ff;
            out_hum_ff  <= skid_hum_ff;
         end else begin
            out_temp_ff <= pipe_temp;
            out_hum_ff  <= pipe_hum;
         end
      end else if (incoming) begin
         skid_temp_ff <= pipe_temp;
         skid_hum_ff  <= pipe_hum;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.temp_centi   = out_temp_ff;
   assign rsp_ch.humidity_q10 = out_hum_ff;

`ifndef SYNTHESIS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds an item while output register is empty");

   a_skid_blocks_req: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !req_ch.ready)
      else $error("input ready while skid entry is occupied");

   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && !rsp_ch.ready))
      else $error("skid filled without an output stall");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (out_hum_ff <= HUM_OUT_MAX))
      else $error("humidity result above full scale");
`endif

endmodule

### src/thc_pipe.sv
module thc_pipe (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic [thc_pkg::RAW_TEMP_W-1:0]  raw_temp,
   input  logic [thc_pkg::RAW_HUM_W-1:0]   raw_humidity,
   input  thc_pkg::coeff_type              coef,
   output logic                            out_valid,
   output logic signed [thc_pkg::TEMP_W-1:0] temp_centi,
   output logic [thc_pkg::HUM_W-1:0]       humidity_q10
);
   import thc_pkg::*;

   localparam int STAGES = 9;

   logic [STAGES-1:0] vld_ff, vld_in;

   // sign/zero extended coefficients
   logic signed [31:0] t1x, t2x, t3x, h1x, h2x, h3x, h4_sh, h5x, h6x;

   // stage 1
   logic signed [31:0] x1, d;
   logic signed [31:0] s1_a_ff, s1_dd_ff;
   logic [RAW_HUM_W-1:0] s1_hum_ff;
   // stage 2
   logic signed [31:0] s2_a_ff, s2_b_ff;
   logic [RAW_HUM_W-1:0] s2_hum_ff;
   // stage 3
   logic signed [31:0] s3_fine_ff;
   logic [RAW_HUM_W-1:0] s3_hum_ff;
   // stage 4
   logic signed [31:0] tc_pre, v;
   logic signed [31:0] s4_tc_ff, s4_v5_ff, s4_v6_ff, s4_v3_ff;
   logic [RAW_HUM_W-1:0] s4_hum_ff;
   // stage 5
   logic signed [31:0] hum_sh, p_pre, q1a, q1b;
   logic signed [TEMP_W-1:0] temp_sat;
   logic signed [31:0] s5_p_ff, s5_q1_ff;
   logic signed [TEMP_W-1:0] s5_temp_ff;
   // stage 6
   logic signed [31:0] q2;
   logic signed [31:0] s6_p_ff, s6_q3_ff;
   logic signed [TEMP_W-1:0] s6_temp_ff;
   // stage 7
   logic signed [31:0] q3_pre, q3;
   logic signed [31:0] s7_v_ff;
   logic signed [TEMP_W-1:0] s7_temp_ff;
   // stage 8
   logic signed [31:0] s;
   logic signed [31:0] s8_v_ff, s8_ss_ff;
   logic signed [TEMP_W-1:0] s8_temp_ff;
   // stage 9
   logic signed [31:0] s9_v_ff, s9_h1_ff;
   logic signed [TEMP_W-1:0] s9_temp_ff;
   // final
   logic signed [31:0] vv;

   assign t1x   = {16'd0, coef.t1};
   assign t2x   = {{16{coef.t2[15]}}, coef.t2};
   assign t3x   = {{16{coef.t3[15]}}, coef.t3};
   assign h1x   = {24'd0, coef.h1};
   assign h3x   = {24'd0, coef.h3};
   assign h2x   = {{16{coef.h2[15]}}, coef.h2};
   assign h4_sh = {coef.h4[11:0], 20'd0};
   assign h5x   = {{16{coef.h5[15]}}, coef.h5};
   assign h6x   = {{24{coef.h6[7]}}, coef.h6};

   assign vld_in = {vld_ff[STAGES-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // datapath math
   assign x1 = {15'd0, raw_temp[19:3]} - {15'd0, coef.t1, 1'b0};
   assign d  = {16'd0, raw_temp[19:4]} - t1x;

   assign tc_pre = (s3_fine_ff <<< 2) + s3_fine_ff + T_ROUND;
   assign v      = s3_fine_ff - FINE_OFFSET;

   assign hum_sh = {2'b00, s4_hum_ff, 14'd0};
   assign p_pre  = hum_sh - h4_sh - s4_v5_ff + P_ROUND;
   assign q1a    = s4_v6_ff >>> 10;
   assign q1b    = (s4_v3_ff >>> 11) + Q_BIAS;

   always_comb begin
      priority if (s4_tc_ff > TEMP_MAX) begin
         temp_sat = TEMP_MAX[TEMP_W-1:0];
      end else if (s4_tc_ff < TEMP_MIN) begin
         temp_sat = TEMP_MIN[TEMP_W-1:0];
      end else begin
         temp_sat = s4_tc_ff[TEMP_W-1:0];
      end
   end

   assign q2     = (s5_q1_ff >>> 10) + Q2_BIAS;
   assign q3_pre = s6_q3_ff + Q3_ROUND;
   assign q3     = q3_pre >>> 14;
   assign s      = s7_v_ff >>> 15;

   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1: first products of the fine temperature
         s1_a_ff   <= x1 * t2x;
         s1_dd_ff  <= d * d;
         s1_hum_ff <= raw_humidity;
         // stage 2: square term
         s2_a_ff   <= s1_a_ff >>> 11;
         s2_b_ff   <= (s1_dd_ff >>> 12) * t3x;
         s2_hum_ff <= s1_hum_ff;
         // stage 3: fine temperature
         s3_fine_ff <= s2_a_ff + (s2_b_ff >>> 14);
         s3_hum_ff  <= s2_hum_ff;
         // stage 4: temperature scale, humidity products on fine offset
         s4_tc_ff  <= tc_pre >>> 8;
         s4_v5_ff  <= v * h5x;
         s4_v6_ff  <= v * h6x;
         s4_v3_ff  <= v * h3x;
         s4_hum_ff <= s3_hum_ff;
         // stage 5
         s5_temp_ff <= temp_sat;
         s5_p_ff    <= p_pre >>> 15;
         s5_q1_ff   <= q1a * q1b;
         // stage 6
         s6_temp_ff <= s5_temp_ff;
         s6_p_ff    <= s5_p_ff;
         s6_q3_ff   <= q2 * h2x;
         // stage 7
         s7_temp_ff <= s6_temp_ff;
         s7_v_ff    <= s6_p_ff * q3;
         // stage 8
         s8_temp_ff <= s7_temp_ff;
         s8_v_ff    <= s7_v_ff;
         s8_ss_ff   <= s * s;
         // stage 9
         s9_temp_ff <= s8_temp_ff;
         s9_v_ff    <= s8_v_ff;
         s9_h1_ff   <= (s8_ss_ff >>> 7) * h1x;
      end
   end

   // final subtract and clamp, registered by the caller
   assign vv = s9_v_ff - (s9_h1_ff >>> 4);

   always_comb begin
      priority if (vv[31]) begin
         humidity_q10 = '0;
      end else if (vv > HUM_CLAMP_MAX) begin
         humidity_q10 = HUM_OUT_MAX;
      end else begin
         humidity_q10 = vv[28:12];
      end
   end

   assign temp_centi = s9_temp_ff;
   assign out_valid  = vld_ff[STAGES-1];

endmodule
